[hdl/ashc_pkg.sv]
// shared types and constants for the audio stream header checker
package ashc_pkg;

  // header layout
  localparam int unsigned HdrBytes   = 28;
  localparam int unsigned CountW     = 16;
  localparam int unsigned NameW      = 128;
  localparam int unsigned FrameW     = 32;
  localparam int unsigned ProdW      = 20;

  // stream header constants
  localparam logic [31:0] MagicWord    = "VBAN";
  localparam logic [4:0]  Rate48kIndex = 5'd3;
  localparam logic [2:0]  TypePcm16    = 3'd1;
  localparam logic [2:0]  TypeFloat32  = 3'd4;

  // queue between capture and verdict
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // verdict codes
  typedef enum logic [3:0] {
    ERR_OK       = 4'd0,
    ERR_SHORT    = 4'd1,
    ERR_MAGIC    = 4'd2,
    ERR_SUBPROTO = 4'd3,
    ERR_RATE     = 4'd4,
    ERR_CODEC    = 4'd5,
    ERR_TYPE     = 4'd6,
    ERR_CHANNELS = 4'd7,
    ERR_LENGTH   = 4'd8
  } err_e;

  // captured datagram, one per request ending in a last byte
  typedef struct packed {
    logic [CountW-1:0] total;
    logic              magic_ok;
    logic [7:0]        rate_byte;
    logic [7:0]        frames_byte;
    logic [7:0]        channels_byte;
    logic [7:0]        format_byte;
    logic [NameW-1:0]  name;
    logic [FrameW-1:0] frame_no;
  } rec_t;

  // magic byte expected at header position 0..3, 'V' first
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = MagicWord[31:24];
      2'd1:    b = MagicWord[23:16];
      2'd2:    b = MagicWord[15:8];
      default: b = MagicWord[7:0];
    endcase
    return b;
  endfunction

endpackage

[hdl/ashc_front.sv]
// byte capture: counts datagram bytes and grabs the header fields
module ashc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_i,
  output logic                push_o,
  output ashc_pkg::rec_t      rec_o
);

  logic [ashc_pkg::CountW-1:0] count_q, count_d;
  logic                        magic_ok_q, magic_ok_d;
  logic [7:0]                  rate_q, rate_d;
  logic [7:0]                  frames_q, frames_d;
  logic [7:0]                  chans_q, chans_d;
  logic [7:0]                  format_q, format_d;
  logic [ashc_pkg::NameW-1:0]  name_q, name_d;
  logic [ashc_pkg::FrameW-1:0] frame_q, frame_d;
  logic [3:0]                  name_lane;

  assign name_lane = 4'(count_q[3:0] - 4'd8);

  // capture the byte at its header position, saturating count
  always_comb begin
    count_d    = count_q;
    magic_ok_d = magic_ok_q;
    rate_d     = rate_q;
    frames_d   = frames_q;
    chans_d    = chans_q;
    format_d   = format_q;
    name_d     = name_q;
    frame_d    = frame_q;
    if (accept_i) begin
      priority if (count_q < 16'd4) begin
        if (data_byte_i != ashc_pkg::magic_byte(count_q[1:0])) magic_ok_d = 1'b0;
      end else if (count_q == 16'd4) begin
        rate_d = data_byte_i;
      end else if (count_q == 16'd5) begin
        frames_d = data_byte_i;
      end else if (count_q == 16'd6) begin
        chans_d = data_byte_i;
      end else if (count_q == 16'd7) begin
        format_d = data_byte_i;
      end else if (count_q < 16'd24) begin
        name_d[8*name_lane +: 8] = data_byte_i;
      end else if (count_q < 16'(ashc_pkg::HdrBytes)) begin
        frame_d[8*count_q[1:0] +: 8] = data_byte_i;
      end else begin
        // past the header, only the count moves
      end
      if (count_q != '1) count_d = 16'(count_q + 16'd1);
    end
  end

  // record of the finished datagram, built from the updated state
  always_comb begin
    rec_o.total         = count_d;
    rec_o.magic_ok      = magic_ok_d;
    rec_o.rate_byte     = rate_d;
    rec_o.frames_byte   = frames_d;
    rec_o.channels_byte = chans_d;
    rec_o.format_byte   = format_d;
    rec_o.name          = name_d;
    rec_o.frame_no      = frame_d;
  end

  assign push_o = accept_i & last_i;

  // state registers, back to reset values after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      magic_ok_q <= 1'b1;
      rate_q     <= '0;
      frames_q   <= '0;
      chans_q    <= '0;
      format_q   <= '0;
      name_q     <= '0;
      frame_q    <= '0;
    end else if (push_o) begin
      count_q    <= '0;
      magic_ok_q <= 1'b1;
      rate_q     <= '0;
      frames_q   <= '0;
      chans_q    <= '0;
      format_q   <= '0;
      name_q     <= '0;
      frame_q    <= '0;
    end else begin
      count_q    <= count_d;
      magic_ok_q <= magic_ok_d;
      rate_q     <= rate_d;
      frames_q   <= frames_d;
      chans_q    <= chans_d;
      format_q   <= format_d;
      name_q     <= name_d;
      frame_q    <= frame_d;
    end
  end

endmodule

[hdl/ashc_queue.sv]
// short record queue between capture and verdict
module ashc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ashc_pkg::rec_t push_rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           nonempty_o,
  output ashc_pkg::rec_t head_o
);

  localparam int unsigned Depth = ashc_pkg::QueueDepth;
  localparam int unsigned PtrW  = ashc_pkg::QueuePtrW;
  localparam int unsigned CntW  = ashc_pkg::QueueCntW;

  ashc_pkg::rec_t      entries_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o     = (count_q == CntW'(Depth));
  assign nonempty_o = (count_q != '0);
  assign head_o     = entries_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= push_rec_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        count_q <= CntW'(count_q + 1'b1);
      end else if (pop_i && !push_i) begin
        count_q <= CntW'(count_q - 1'b1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> nonempty_o)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count out of range");
`endif

endmodule

[hdl/ashc_judge.sv]
// verdict pipeline: header checks and length product, then length compare
module ashc_judge #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rec_valid_i,
  input  ashc_pkg::rec_t rec_i,
  output logic           rec_take_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           accepted_o,
  output logic [3:0]     error_code_o,
  output logic [8:0]     samples_per_frame_o,
  output logic [8:0]     channel_count_o,
  output logic [2:0]     sample_type_o,
  output logic [31:0]    frame_number_o,
  output logic [63:0]    name_low_bytes_o,
  output logic [63:0]    name_high_bytes_o
);

  localparam int unsigned PW = ashc_pkg::ProdW;

  // stage A registers
  logic                          a_v_q;
  ashc_pkg::err_e                a_err_q, a_err_d;
  logic [PW-1:0]                 a_prod_q, a_prod_d;
  logic [ashc_pkg::CountW-1:0]   a_total_q;
  logic [8:0]                    a_spf_q, a_ch_q;
  logic [2:0]                    a_type_q;
  logic [ashc_pkg::FrameW-1:0]   a_frame_q;
  logic [ashc_pkg::NameW-1:0]    a_name_q;

  // stage B (output) registers
  logic                          b_v_q;
  ashc_pkg::err_e                b_err_q, b_err_d;

  logic [8:0]  spf, ch;
  logic [2:0]  stype;
  logic [17:0] frame_prod;
  logic [PW-1:0] expected;
  logic        b_ready, a_ready;

  assign b_ready    = !b_v_q || !out_stall_i;
  assign a_ready    = !a_v_q || b_ready;
  assign rec_take_o = rec_valid_i && a_ready;

  assign spf        = 9'(rec_i.frames_byte) + 9'd1;
  assign ch         = 9'(rec_i.channels_byte) + 9'd1;
  assign stype      = rec_i.format_byte[2:0];
  assign frame_prod = 18'(spf) * 18'(ch);

  // header checks in order, first failure wins
  always_comb begin
    priority if (rec_i.total < 16'(ashc_pkg::HdrBytes)) begin
      a_err_d = ashc_pkg::ERR_SHORT;
    end else if (!rec_i.magic_ok) begin
      a_err_d = ashc_pkg::ERR_MAGIC;
    end else if (rec_i.rate_byte[7:5] != 3'd0) begin
      a_err_d = ashc_pkg::ERR_SUBPROTO;
    end else if (rec_i.rate_byte[4:0] != ashc_pkg::Rate48kIndex) begin
      a_err_d = ashc_pkg::ERR_RATE;
    end else if (rec_i.format_byte[7:4] != 4'd0) begin
      a_err_d = ashc_pkg::ERR_CODEC;
    end else if (stype != ashc_pkg::TypePcm16 && stype != ashc_pkg::TypeFloat32) begin
      a_err_d = ashc_pkg::ERR_TYPE;
    end else if (ch > 9'(MAX_CHANNELS)) begin
      a_err_d = ashc_pkg::ERR_CHANNELS;
    end else begin
      a_err_d = ashc_pkg::ERR_OK;
    end
  end

  // payload bytes: two per sample for pcm16, four for float32
  assign a_prod_d = (stype == ashc_pkg::TypeFloat32) ? {frame_prod, 2'b00}
                                                     : {1'b0, frame_prod, 1'b0};

  // length compare against the header-derived size
  assign expected = PW'(ashc_pkg::HdrBytes) + a_prod_q;
  always_comb begin
    b_err_d = a_err_q;
    if (a_err_q == ashc_pkg::ERR_OK && PW'(a_total_q) != expected) begin
      b_err_d = ashc_pkg::ERR_LENGTH;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_ready) a_v_q <= rec_valid_i;
      if (b_ready) b_v_q <= a_v_q;
    end
  end

  // stage A payload
  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      a_err_q   <= a_err_d;
      a_prod_q  <= a_prod_d;
      a_total_q <= rec_i.total;
      a_spf_q   <= spf;
      a_ch_q    <= ch;
      a_type_q  <= stype;
      a_frame_q <= rec_i.frame_no;
      a_name_q  <= rec_i.name;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (b_ready && a_v_q) begin
      b_err_q             <= b_err_d;
      samples_per_frame_o <= a_spf_q;
      channel_count_o     <= a_ch_q;
      sample_type_o       <= a_type_q;
      frame_number_o      <= a_frame_q;
      name_low_bytes_o    <= a_name_q[63:0];
      name_high_bytes_o   <= a_name_q[127:64];
    end
  end

  assign out_valid_o  = b_v_q;
  assign error_code_o = b_err_q;
  assign accepted_o   = (b_err_q == ashc_pkg::ERR_OK);

`ifndef SYNTH
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_v_q && !b_ready) |=> a_v_q)
    else $error("stage A dropped a record while output blocked");
  a_no_take_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_v_q && b_v_q && out_stall_i) |-> !rec_take_o)
    else $error("record taken while pipeline full and stalled");
`endif

endmodule

[hdl/audio_stream_header_checker.sv]
// audio stream header checker top level: capture, queue and verdict
// Throughput: one datagram byte per cycle while the record queue is not full;
// one verdict per cycle at most. After the last byte is taken, the verdict passes through
// the queue write, the check/product stage and the length compare stage.
// Input stall rises only while the two-entry record queue is full.
// Reset (rst_ni low, asynchronous) clears the byte count, captured header and queue.
module audio_stream_header_checker #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [3:0]  error_code_o,
  output logic [8:0]  samples_per_frame_o,
  output logic [8:0]  channel_count_o,
  output logic [2:0]  sample_type_o,
  output logic [31:0] frame_number_o,
  output logic [63:0] name_low_bytes_o,
  output logic [63:0] name_high_bytes_o
);

  logic           in_accept;
  logic           push;
  logic           full;
  logic           nonempty;
  logic           pop;
  ashc_pkg::rec_t push_rec;
  ashc_pkg::rec_t head_rec;

  assign in_stall_o = full;
  assign in_accept  = in_valid_i && !in_stall_o;

  // front: byte capture
  ashc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  // record queue
  ashc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .head_o     (head_rec)
  );

  // back: verdict pipeline
  ashc_judge #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_judge (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .rec_valid_i         (nonempty),
    .rec_i               (head_rec),
    .rec_take_o          (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .accepted_o          (accepted_o),
    .error_code_o        (error_code_o),
    .samples_per_frame_o (samples_per_frame_o),
    .channel_count_o     (channel_count_o),
    .sample_type_o       (sample_type_o),
    .frame_number_o      (frame_number_o),
    .name_low_bytes_o    (name_low_bytes_o),
    .name_high_bytes_o   (name_high_bytes_o)
  );

endmodule

[tb/audio_stream_header_checker_test.sv]
// self-checking testbench for the audio stream header checker
module audio_stream_header_checker_test;

  localparam int unsigned MaxChannels     = 8;
  localparam int unsigned TotalBytes      = 1150;
  localparam int unsigned MinRandomFrames = 12;
  localparam int unsigned HoldCycles      = 3000;
  localparam int unsigned DrainLimit      = 40000;
  localparam int unsigned TimeoutCycles   = 4000000;
  localparam logic [7:0]  RateOk          = {3'b000, ashc_pkg::Rate48kIndex};
  localparam logic [7:0]  FmtPcm          = {5'b00000, ashc_pkg::TypePcm16};
  localparam logic [7:0]  FmtFloat        = {5'b00000, ashc_pkg::TypeFloat32};

  typedef logic [7:0] byte_q_t[$];

  // one verdict as seen on the result port
  typedef struct {
    logic        accepted;
    logic [3:0]  code;
    logic [8:0]  spf;
    logic [8:0]  chans;
    logic [2:0]  stype;
    logic [31:0] frame_no;
    logic [63:0] name_lo;
    logic [63:0] name_hi;
  } verdict_t;

  // header tracker and store of expected verdicts
  class verdict_board;
    logic [15:0] cnt;
    logic        magic_ok;
    logic [7:0]  rate_b;
    logic [7:0]  frames_b;
    logic [7:0]  chans_b;
    logic [7:0]  fmt_b;
    logic [7:0]  name_b[16];
    logic [31:0] frame_no;
    verdict_t    expected_q[$];
    int          mismatches;
    int          bytes_seen;
    int          verdicts_seen;
    int          accepted_seen;
    int          code_hits[9];

    function new();
      clear_header();
    endfunction

    function void clear_header();
      cnt      = '0;
      magic_ok = 1'b1;
      rate_b   = '0;
      frames_b = '0;
      chans_b  = '0;
      fmt_b    = '0;
      foreach (name_b[i]) name_b[i] = '0;
      frame_no = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // capture one accepted byte, predict the verdict on a last byte
    function void note_byte(logic [7:0] b, logic is_last);
      verdict_t         v;
      ashc_pkg::err_e   code;
      logic [2:0]       stype;
      int unsigned      idx;
      int unsigned      spf;
      int unsigned      ch;
      int unsigned      bps;
      idx = cnt;
      bytes_seen++;
      if (idx < 4) begin
        if (b != ashc_pkg::MagicWord[31 - 8*idx -: 8]) magic_ok = 1'b0;
      end else if (idx == 4) begin
        rate_b = b;
      end else if (idx == 5) begin
        frames_b = b;
      end else if (idx == 6) begin
        chans_b = b;
      end else if (idx == 7) begin
        fmt_b = b;
      end else if (idx < 24) begin
        name_b[idx - 8] = b;
      end else if (idx < ashc_pkg::HdrBytes) begin
        frame_no[8*(idx - 24) +: 8] = b;
      end
      if (cnt != 16'hFFFF) cnt = cnt + 16'd1;
      if (!is_last) return;

      // checks in priority order, first failure wins
      spf   = frames_b + 1;
      ch    = chans_b + 1;
      stype = fmt_b[2:0];
      if (cnt < ashc_pkg::HdrBytes) begin
        code = ashc_pkg::ERR_SHORT;
      end else if (!magic_ok) begin
        code = ashc_pkg::ERR_MAGIC;
      end else if (rate_b[7:5] != 3'd0) begin
        code = ashc_pkg::ERR_SUBPROTO;
      end else if (rate_b[4:0] != ashc_pkg::Rate48kIndex) begin
        code = ashc_pkg::ERR_RATE;
      end else if (fmt_b[7:4] != 4'd0) begin
        code = ashc_pkg::ERR_CODEC;
      end else if (stype != ashc_pkg::TypePcm16 && stype != ashc_pkg::TypeFloat32) begin
        code = ashc_pkg::ERR_TYPE;
      end else if (ch > MaxChannels) begin
        code = ashc_pkg::ERR_CHANNELS;
      end else begin
        bps = (stype == ashc_pkg::TypeFloat32) ? 4 : 2;
        if (cnt == ashc_pkg::HdrBytes + spf * ch * bps) code = ashc_pkg::ERR_OK;
        else                                            code = ashc_pkg::ERR_LENGTH;
      end

      v.accepted = (code == ashc_pkg::ERR_OK);
      v.code     = code;
      v.spf      = {1'b0, frames_b} + 9'd1;
      v.chans    = {1'b0, chans_b} + 9'd1;
      v.stype    = stype;
      v.frame_no = frame_no;
      for (int i = 0; i < 8; i++) begin
        v.name_lo[8*i +: 8] = name_b[i];
        v.name_hi[8*i +: 8] = name_b[8 + i];
      end
      expected_q.push_back(v);
      clear_header();
    endfunction

    function void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("verdict %0d: %s expected %h, got %h", verdicts_seen, what, want, got);
      end
    endfunction

    // compare one verdict from the block with the oldest prediction
    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("verdict with code %0d arrived with none expected", got.code);
        return;
      end
      want = expected_q.pop_front();
      verdicts_seen++;
      if (want.accepted) accepted_seen++;
      code_hits[want.code]++;
      check_field("accepted", want.accepted, got.accepted);
      check_field("error_code", want.code, got.code);
      check_field("samples_per_frame", want.spf, got.spf);
      check_field("channel_count", want.chans, got.chans);
      check_field("sample_type", want.stype, got.stype);
      check_field("frame_number", want.frame_no, got.frame_no);
      check_field("name_low_bytes", want.name_lo, got.name_lo);
      check_field("name_high_bytes", want.name_hi, got.name_hi);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        accepted_o;
  logic [3:0]  error_code_o;
  logic [8:0]  samples_per_frame_o;
  logic [8:0]  channel_count_o;
  logic [2:0]  sample_type_o;
  logic [31:0] frame_number_o;
  logic [63:0] name_low_bytes_o;
  logic [63:0] name_high_bytes_o;

  verdict_board board = new();
  int           sender_idle_pct    = 0;
  int           receiver_stall_pct = 0;
  logic         hold_on            = 1'b0;

  audio_stream_header_checker #(
    .MAX_CHANNELS(MaxChannels)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .last_i             (last_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .accepted_o         (accepted_o),
    .error_code_o       (error_code_o),
    .samples_per_frame_o(samples_per_frame_o),
    .channel_count_o    (channel_count_o),
    .sample_type_o      (sample_type_o),
    .frame_number_o     (frame_number_o),
    .name_low_bytes_o   (name_low_bytes_o),
    .name_high_bytes_o  (name_high_bytes_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: check taken verdicts, then pick the next stall
  always @(posedge clk_i) begin : collect
    verdict_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.accepted = accepted_o;
      got.code     = error_code_o;
      got.spf      = samples_per_frame_o;
      got.chans    = channel_count_o;
      got.stype    = sample_type_o;
      got.frame_no = frame_number_o;
      got.name_lo  = name_low_bytes_o;
      got.name_hi  = name_high_bytes_o;
      board.check_verdict(got);
    end
    out_stall_i <= hold_on || ($urandom_range(99, 0) < receiver_stall_pct);
  end

  // watchdog
  initial begin
    #(12 * TimeoutCycles);
    $display("timeout with %0d verdicts outstanding", board.pending());
    $display("DONE: errors detected");
    $finish;
  end

  // good datagram length for a header
  function automatic int unsigned good_len(logic [7:0] frames, logic [7:0] chans,
                                           logic [7:0] fmt);
    return ashc_pkg::HdrBytes + (frames + 1) * (chans + 1) *
           ((fmt[2:0] == ashc_pkg::TypeFloat32) ? 4 : 2);
  endfunction

  // datagram with the magic, the given header fields and random name, counter, payload
  function automatic byte_q_t frame_bytes(logic [7:0] rate, logic [7:0] frames,
                                          logic [7:0] chans, logic [7:0] fmt,
                                          int unsigned total);
    byte_q_t q;
    for (int unsigned i = 0; i < total; i++) begin
      if (i < 4)       q.push_back(ashc_pkg::MagicWord[31 - 8*i -: 8]);
      else if (i == 4) q.push_back(rate);
      else if (i == 5) q.push_back(frames);
      else if (i == 6) q.push_back(chans);
      else if (i == 7) q.push_back(fmt);
      else             q.push_back(8'($urandom));
    end
    return q;
  endfunction

  task automatic set_phase(int unsigned p);
    case (p)
      0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
      1: begin sender_idle_pct = 61; receiver_stall_pct <= 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct <= 61; end
      default: begin sender_idle_pct = 15; receiver_stall_pct <= 15; end
    endcase
  endtask

  // offer one byte, hold it until the request is taken
  task automatic offer_byte(logic [7:0] b, logic is_last);
    while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_i      <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_byte(b, is_last);
  endtask

  task automatic send_q(byte_q_t q);
    for (int i = 0; i < q.size(); i++) offer_byte(q[i], i == q.size() - 1);
  endtask

  task automatic send_case(logic [7:0] rate, logic [7:0] frames, logic [7:0] chans,
                           logic [7:0] fmt, int unsigned total);
    send_q(frame_bytes(rate, frames, chans, fmt, total));
  endtask

  // sender pause until every verdict is in
  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (board.pending() != 0 && waited < DrainLimit);
  endtask

  // mostly well-formed datagrams, some with one defect, some noise
  task automatic send_random_frame();
    logic [7:0]      rate;
    logic [7:0]      frames;
    logic [7:0]      chans;
    logic [7:0]      fmt;
    int unsigned     total;
    int unsigned     kind;
    int unsigned     t;
    bit              bad_magic;
    ashc_pkg::err_e  defect;
    byte_q_t         q;
    rate      = RateOk;
    frames    = ($urandom_range(24, 0) == 0) ? 8'($urandom_range(15, 0))
                                             : 8'($urandom_range(1, 0));
    chans     = 8'($urandom_range(MaxChannels - 1, 0));
    fmt       = {4'h0, 1'($urandom_range(1, 0)),
                 ($urandom_range(1, 0) != 0) ? ashc_pkg::TypeFloat32 : ashc_pkg::TypePcm16};
    total     = good_len(frames, chans, fmt);
    bad_magic = 1'b0;
    kind      = $urandom_range(99, 0);
    if (kind >= 90) begin
      total = $urandom_range(60, 1);
      repeat (total) q.push_back(8'($urandom));
      send_q(q);
      return;
    end
    if (kind >= 60) begin
      defect = ashc_pkg::err_e'($urandom_range(ashc_pkg::ERR_LENGTH, ashc_pkg::ERR_SHORT));
      case (defect)
        ashc_pkg::ERR_SHORT:    total = $urandom_range(ashc_pkg::HdrBytes - 1, 1);
        ashc_pkg::ERR_MAGIC:    bad_magic = 1'b1;
        ashc_pkg::ERR_SUBPROTO: rate[7:5] = 3'($urandom_range(7, 1));
        ashc_pkg::ERR_RATE:     rate[4:0] = ashc_pkg::Rate48kIndex + 5'($urandom_range(31, 1));
        ashc_pkg::ERR_CODEC:    fmt[7:4] = 4'($urandom_range(15, 1));
        ashc_pkg::ERR_TYPE: begin
          do t = $urandom_range(7, 0);
          while (t == ashc_pkg::TypePcm16 || t == ashc_pkg::TypeFloat32);
          fmt[2:0] = 3'(t);
        end
        ashc_pkg::ERR_CHANNELS: begin
          chans = 8'($urandom_range(255, MaxChannels));
          total = ashc_pkg::HdrBytes + $urandom_range(40, 0);
        end
        default: begin
          if ($urandom_range(1, 0) != 0) total = total + $urandom_range(4, 1);
          else                           total = total - $urandom_range(2, 1);
        end
      endcase
    end
    q = frame_bytes(rate, frames, chans, fmt, total);
    if (bad_magic) q[$urandom_range(3, 0)] ^= 8'($urandom_range(255, 1));
    send_q(q);
  endtask

  // stimulus
  initial begin : stimulus
    byte_q_t     q;
    int unsigned n;
    int unsigned waited;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_phase(0);

    // valid headers with name and counter at all zeros and all ones
    q = frame_bytes(RateOk, 8'd0, 8'd0, FmtPcm, good_len(8'd0, 8'd0, FmtPcm));
    for (int i = 8; i < ashc_pkg::HdrBytes; i++) q[i] = 8'h00;
    send_q(q);
    q = frame_bytes(RateOk, 8'd0, 8'(MaxChannels - 1), FmtFloat | 8'h08,
                    good_len(8'd0, 8'(MaxChannels - 1), FmtFloat));
    for (int i = 8; i < ashc_pkg::HdrBytes; i++) q[i] = 8'hFF;
    send_q(q);
    // largest frame count, with a length that does not match
    send_case(RateOk, 8'hFF, 8'd0, FmtPcm, 40);
    // short datagrams, and a bare header
    send_case(RateOk, 8'd0, 8'd0, FmtPcm, 1);
    send_case(RateOk, 8'd3, 8'd1, FmtPcm, ashc_pkg::HdrBytes - 1);
    send_case(RateOk, 8'd0, 8'd0, FmtPcm, ashc_pkg::HdrBytes);
    // bad magic at each position
    for (int k = 0; k < 4; k++) begin
      q = frame_bytes(RateOk, 8'd0, 8'd0, FmtPcm, good_len(8'd0, 8'd0, FmtPcm));
      q[k] ^= 8'h20;
      send_q(q);
    end
    // sub-protocol, rate, codec and type failures
    send_case(8'hE3, 8'd0, 8'd0, FmtPcm, good_len(8'd0, 8'd0, FmtPcm));
    send_case(8'h00, 8'd0, 8'd0, FmtPcm, good_len(8'd0, 8'd0, FmtPcm));
    send_case(8'h1F, 8'd0, 8'd0, FmtPcm, good_len(8'd0, 8'd0, FmtPcm));
    send_case(RateOk, 8'd0, 8'd0, 8'hF1, good_len(8'd0, 8'd0, FmtPcm));
    send_case(RateOk, 8'd0, 8'd0, 8'h00, good_len(8'd0, 8'd0, FmtPcm));
    send_case(RateOk, 8'd0, 8'd0, 8'h07, good_len(8'd0, 8'd0, FmtPcm));
    // too many channels, at the top of the byte and just over the limit
    send_case(RateOk, 8'd0, 8'hFF, FmtPcm, 40);
    send_case(RateOk, 8'd0, 8'(MaxChannels), FmtPcm, 40);
    // length off by one, then an exact float32 length
    send_case(RateOk, 8'd1, 8'd1, FmtPcm, good_len(8'd1, 8'd1, FmtPcm) + 1);
    send_case(RateOk, 8'd1, 8'd0, FmtFloat, good_len(8'd1, 8'd0, FmtFloat));
    drain();

    // random datagrams, idling phase changes every three
    for (n = 0; board.bytes_seen < TotalBytes || n < MinRandomFrames; n++) begin
      if (n % 3 == 0) set_phase((n / 3) % 4);
      // long receiver hold-off while the sender keeps going
      if (n == 1) begin
        fork
          begin
            hold_on <= 1'b1;
            repeat (HoldCycles) @(posedge clk_i);
            hold_on <= 1'b0;
          end
        join_none
      end
      if (n == 10) drain();
      send_random_frame();
    end

    // wait out the last verdicts, then watch for strays
    in_valid_i <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (board.pending() != 0 && waited < DrainLimit);
    repeat (8) @(posedge clk_i);

    if (board.pending() != 0) begin
      board.mismatches++;
      $display("%0d expected verdicts never arrived", board.pending());
    end
    $display("checked %0d verdicts over %0d bytes, %0d of them accepted",
             board.verdicts_seen, board.bytes_seen, board.accepted_seen);
    $display("verdict counts by code ok..length: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             board.code_hits[0], board.code_hits[1], board.code_hits[2],
             board.code_hits[3], board.code_hits[4], board.code_hits[5],
             board.code_hits[6], board.code_hits[7], board.code_hits[8]);
    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ashc_pkg.sv
hdl/ashc_front.sv
hdl/ashc_queue.sv
hdl/ashc_judge.sv
hdl/audio_stream_header_checker.sv
tb/audio_stream_header_checker_test.sv
